[src/b64enc_pkg.sv]
package b64enc_pkg;

    typedef struct packed
    {
        logic [7:0] in_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed
    {
        logic [7:0] out_char;
        logic       last_char;
    } out_item_t;

    // One 24-bit group queued between the front and the back
    typedef struct packed
    {
        logic [23:0] group;
        logic [1:0]  zeros;
        logic        fin;
    } group_t;

    localparam int unsigned SEXTET_W  = 6;
    localparam logic [1:0]  MAX_HELD  = 2'd2;
    localparam logic [1:0]  LAST_SLOT = 2'd3;
    localparam logic [2:0]  NUM_SLOTS = 3'd4;
    localparam logic [7:0]  PAD_CHAR  = 8'h00;

    function automatic logic [7:0] b64_char(input logic [SEXTET_W-1:0] idx);
        logic [7:0] wide;
        wide = {2'b00, idx};
        if (idx < 6'd26)
        begin
            return 8'h41 + wide;
        end
        else if (idx < 6'd52)
        begin
            return 8'h61 + wide - 8'd26;
        end
        else if (idx < 6'd62)
        begin
            return 8'h30 + wide - 8'd52;
        end
        else if (idx == 6'd62)
        begin
            return 8'h2B;
        end
        else
        begin
            return 8'h2F;
        end
    endfunction

endpackage

[src/base64_stream_encoder_top.sv]
// Base64 stream encoder.
// Input channel src: one byte per transaction with final_byte set on the last
// byte of a message. Output channel dst: one character per transaction, with
// last_char set on the fourth character of the final group. A short final
// group gives zero bytes where padding would stand.
// The front collects bytes into 24-bit groups and accepts one byte per cycle
// while the group queue has room. The back turns the queued group at the head
// into four characters, one per cycle while dst does not stall, through an
// output register. With the back idle, the group that completes is written
// into the queue and then its first character is loaded into the output
// register, which raises dst_valid; the rest follow one per cycle while dst
// does not stall. The single character path of the back sets the sustained
// rate; bursts up to QUEUE_DEPTH groups are absorbed at one byte per cycle.
// Reset clears the held bytes, the queue and the output valid.
// A stall on dst holds the current character; the back stops, the queue fills
// and then src_stall rises until a group slot frees up.
module base64_stream_encoder_top
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  b64enc_pkg::in_item_t  src_data,
    output logic                  dst_valid,
    input  logic                  dst_stall,
    output b64enc_pkg::out_item_t dst_data
);
    import b64enc_pkg::*;

    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    group_t q_entry;
    group_t q_head;

    b64enc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    b64enc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_entry),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    b64enc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

endmodule

[src/b64enc_front.sv]
module b64enc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  b64enc_pkg::in_item_t src_data,
    input  logic                q_full,
    output logic                q_push,
    output b64enc_pkg::group_t  q_entry
);
    import b64enc_pkg::*;

    logic [15:0] pending_bytes_reg;
    logic [15:0] pending_bytes_next;
    logic [1:0]  pending_count_reg;
    logic [1:0]  pending_count_next;
    logic [1:0]  held;
    logic        accept;
    logic        collect;

    // Saturate a corrupt count at two held bytes
    assign held      = (pending_count_reg > MAX_HELD) ? MAX_HELD : pending_count_reg;
    assign src_stall = q_full;
    assign accept    = src_valid && !src_stall;
    assign collect   = !src_data.final_byte && (held < MAX_HELD);
    assign q_push    = accept && !collect;

    always_comb
    begin
        unique case (held)
            2'd0:    q_entry.group = {src_data.in_byte, 16'h0000};
            2'd1:    q_entry.group = {pending_bytes_reg[7:0], src_data.in_byte, 8'h00};
            default: q_entry.group = {pending_bytes_reg, src_data.in_byte};
        endcase
        q_entry.zeros = src_data.final_byte ? (MAX_HELD - held) : 2'd0;
        q_entry.fin   = src_data.final_byte;
    end

    always_comb
    begin
        pending_bytes_next = pending_bytes_reg;
        pending_count_next = pending_count_reg;
        if (accept)
        begin
            if (collect)
            begin
                pending_bytes_next = {pending_bytes_reg[7:0], src_data.in_byte};
                pending_count_next = held + 2'd1;
            end
            else
            begin
                pending_bytes_next = 16'h0000;
                pending_count_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bytes_reg <= 16'h0000;
            pending_count_reg <= 2'd0;
        end
        else
        begin
            pending_bytes_reg <= pending_bytes_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

[src/b64enc_fifo.sv]
module b64enc_fifo
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64enc_pkg::group_t push_data,
    input  logic               pop,
    output b64enc_pkg::group_t head,
    output logic               full,
    output logic               empty
);
    import b64enc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    group_t           entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push)
        else $error("group queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("group queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("group queue count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("group queue count did not advance on write");

endmodule

[src/b64enc_back.sv]
module b64enc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  b64enc_pkg::group_t   head,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output b64enc_pkg::out_item_t dst_data
);
    import b64enc_pkg::*;

    logic [1:0]          slot_reg;
    logic [1:0]          slot_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_data_reg;
    logic                load;
    logic                blank;
    logic [SEXTET_W-1:0] sextet;
    out_item_t           item;

    assign load  = !q_empty && (!out_valid_reg || !dst_stall);
    assign q_pop = load && (slot_reg == LAST_SLOT);
    // Trailing slots of a short final group carry a zero byte
    assign blank = ({1'b0, slot_reg} + {1'b0, head.zeros}) >= NUM_SLOTS;

    always_comb
    begin
        unique case (slot_reg)
            2'd0:    sextet = head.group[23:18];
            2'd1:    sextet = head.group[17:12];
            2'd2:    sextet = head.group[11:6];
            default: sextet = head.group[5:0];
        endcase
        item.out_char  = blank ? PAD_CHAR : b64_char(sextet);
        item.last_char = head.fin && (slot_reg == LAST_SLOT);
    end

    always_comb
    begin
        slot_next      = load ? slot_reg + 2'd1 : slot_reg;
        out_valid_next = load ? 1'b1 : (out_valid_reg && dst_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= item;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_data  = out_data_reg;

endmodule
